FILE: hdl/wlaf_pkg.sv
// ============================================================================
// Warm-up leaky average filter package
// Shared widths, defaults, state encoding and the controller/datapath structs.
// ============================================================================
`default_nettype none

package wlaf_pkg;

    // Fixed field and state widths.
    localparam int SAMPLE_W = 12;
    localparam int AVG_W    = 12;
    localparam int SUM_W    = 16;

    // The warm-up divider produces one quotient bit per cycle over the sum width.
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    // Largest value the average field can carry.
    localparam logic [SUM_W-1:0] AVG_MAX = SUM_W'((1 << AVG_W) - 1);

    // Parameter defaults.
    localparam int WINDOW_DEF      = 16;
    localparam int SAMPLE_BITS_DEF = 12;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_WDIV,
        S_LDIV,
        S_LEAK,
        S_FDIV,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic win_div;
        logic leak;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic warm;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

FILE: hdl/wlaf_sample_if.sv
// ============================================================================
// Sample channel
// Valid/ready channel that carries one raw converter sample per word.
// ============================================================================
`default_nettype none

interface wlaf_sample_if;

    logic                          valid;
    logic                          ready;
    logic [wlaf_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

`default_nettype wire

FILE: hdl/wlaf_average_if.sv
// ============================================================================
// Average channel
// Valid/ready channel that carries one filtered value per word.
// ============================================================================
`default_nettype none

interface wlaf_average_if;

    logic                       valid;
    logic                       ready;
    logic [wlaf_pkg::AVG_W-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);

endinterface

`default_nettype wire

FILE: hdl/warmup_leaky_average_filter_unit.sv
// Warm-up: setup, 16 serial quotient steps and the output load per sample.
// After warm-up: window division, leak update, window division, output load.
// A new sample is accepted only once the previous result is loaded into the
// output register, so a stalled receiver holds off the next sample.
// Reset (synchronous, active low) clears the running sum, fill count,
// controller state and output valid; no clearing pass is needed.
// ============================================================================
// Warm-up leaky average filter
// Averages converter samples over a growing count, then as a leaky sum.
// ============================================================================
`default_nettype none

module warmup_leaky_average_filter_unit #(
    parameter int WINDOW      = wlaf_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = wlaf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    wlaf_sample_if.sink     i_sample_ch,
    wlaf_average_if.source  o_average_ch
);

    wlaf_pkg::t_cmd    w_cmd;
    wlaf_pkg::t_status w_status;
    logic              w_in_ready;

    // Sequencing of each sample.
    wlaf_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample_ch.valid),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    assign i_sample_ch.ready = w_in_ready;

    // Arithmetic and result register.
    wlaf_datapath #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (i_sample_ch.sample),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_average_ch (o_average_ch)
    );

endmodule

`default_nettype wire

FILE: hdl/wlaf_datapath.sv
// ============================================================================
// Filter datapath
// Running sum, fill count, serial restoring divider for warm-up, reciprocal
// multiplier for the division by the window, and output register.
// ============================================================================
`default_nettype none

module wlaf_datapath #(
    parameter int WINDOW      = wlaf_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = wlaf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [wlaf_pkg::SAMPLE_W-1:0] i_sample,
    input  wire wlaf_pkg::t_cmd                i_cmd,
    output wlaf_pkg::t_status                  o_status,
    wlaf_average_if.source                     o_average_ch
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = wlaf_pkg::SUM_W;
    localparam int SMP_W = wlaf_pkg::SAMPLE_W;
    localparam logic [CNT_W-1:0] WIN_C = CNT_W'(WINDOW);
    localparam logic [SMP_W-1:0] SAMPLE_MASK =
        (SAMPLE_BITS >= SMP_W) ? {SMP_W{1'b1}} : SMP_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [SUM_W:0] SUM_SAT = {1'b0, {SUM_W{1'b1}}};

    // Reciprocal of the window, rounded up, exact for every sum of SUM_W bits.
    localparam int     DIV_L  = $clog2(WINDOW);
    localparam int     DIV_SH = SUM_W + DIV_L;
    localparam int     PROD_W = SUM_W + DIV_SH;
    localparam longint DIV_M  =
        ((longint'(1) << DIV_SH) + longint'(WINDOW) - longint'(1)) / longint'(WINDOW);
    localparam logic [SUM_W+1:0] RECIP = (SUM_W + 2)'(DIV_M);

    logic [SUM_W-1:0]           r_sum;
    logic [CNT_W-1:0]           r_count;
    logic [SMP_W-1:0]           r_x;
    logic [SUM_W-1:0]           r_dvd;
    logic [CNT_W-1:0]           r_rem;
    logic [wlaf_pkg::AVG_W-1:0] r_avg;
    logic                       r_out_valid;

    logic [SMP_W-1:0]  w_x;
    logic [SUM_W:0]    w_add;
    logic [SUM_W-1:0]  w_add_sat;
    logic [SUM_W:0]    w_leak;
    logic [SUM_W-1:0]  w_leak_sat;
    logic [CNT_W-1:0]  w_divisor;
    logic [CNT_W:0]    w_rem_sh;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;
    logic [PROD_W-1:0] w_prod;
    logic [SUM_W-1:0]  w_q_win;

    // Masked sample and the saturating warm-up sum.
    assign w_x       = i_sample & SAMPLE_MASK;
    assign w_add     = {1'b0, r_sum} + (SUM_W + 1)'(w_x);
    assign w_add_sat = (w_add > SUM_SAT) ? {SUM_W{1'b1}} : w_add[SUM_W-1:0];

    // Leak step: the quotient register holds sum / WINDOW at this point.
    assign w_leak     = {1'b0, r_sum - r_dvd} + (SUM_W + 1)'(r_x);
    assign w_leak_sat = (w_leak > SUM_SAT) ? {SUM_W{1'b1}} : w_leak[SUM_W-1:0];

    // Sum over the window by multiplication with the rounded-up reciprocal.
    assign w_prod  = PROD_W'(r_sum) * PROD_W'(RECIP);
    assign w_q_win = w_prod[PROD_W-1:DIV_SH];

    // One restoring division step by the fill count.
    assign w_divisor = r_count;
    assign w_rem_sh  = {r_rem, r_dvd[SUM_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, w_divisor});
    assign w_diff    = w_rem_sh - {1'b0, w_divisor};

    // Sum and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_cmd.load && (r_count < WIN_C)) begin
            r_sum   <= w_add_sat;
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.leak) begin
            r_sum <= w_leak_sat;
        end
    end

    // Sample hold and divider registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= w_x;
        end
        if (i_cmd.div_init) begin
            r_dvd <= r_sum;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_rem_sh[CNT_W-1:0];
        end else if (i_cmd.win_div) begin
            r_dvd <= w_q_win;
        end
    end

    // Output register with saturation to the field range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_average_ch.ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_avg <= (r_dvd > wlaf_pkg::AVG_MAX) ? wlaf_pkg::AVG_W'(wlaf_pkg::AVG_MAX)
                                                  : r_dvd[wlaf_pkg::AVG_W-1:0];
        end
    end

    assign o_average_ch.valid   = r_out_valid;
    assign o_average_ch.average = r_avg;

    assign o_status.warm     = (r_count < WIN_C);
    assign o_status.out_free = !r_out_valid || o_average_ch.ready;

endmodule

`default_nettype wire

FILE: hdl/wlaf_controller.sv
// ============================================================================
// Filter controller
// Sequences warm-up or leak updates and the divider passes for each sample.
// ============================================================================
`default_nettype none

module wlaf_controller (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire wlaf_pkg::t_status i_status,
    output logic                   o_in_ready,
    output wlaf_pkg::t_cmd         o_cmd
);

    wlaf_pkg::t_state r_state;
    wlaf_pkg::t_state n_state;
    logic [wlaf_pkg::STEP_W-1:0] r_step;
    logic [wlaf_pkg::STEP_W-1:0] n_step;

    // State and step counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wlaf_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            wlaf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.warm ? wlaf_pkg::S_PREP : wlaf_pkg::S_LDIV;
                end
            end
            wlaf_pkg::S_PREP: begin
                o_cmd.div_init = 1'b1;
                n_step         = '0;
                n_state        = wlaf_pkg::S_WDIV;
            end
            wlaf_pkg::S_WDIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + wlaf_pkg::STEP_W'(1);
                if (r_step == wlaf_pkg::STEP_LAST) begin
                    n_state = wlaf_pkg::S_OUT;
                end
            end
            wlaf_pkg::S_LDIV: begin
                o_cmd.win_div = 1'b1;
                n_state       = wlaf_pkg::S_LEAK;
            end
            wlaf_pkg::S_LEAK: begin
                o_cmd.leak = 1'b1;
                n_state    = wlaf_pkg::S_FDIV;
            end
            wlaf_pkg::S_FDIV: begin
                o_cmd.win_div = 1'b1;
                n_state       = wlaf_pkg::S_OUT;
            end
            wlaf_pkg::S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = wlaf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wlaf_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // An accepted sample always starts a warm-up or a leak sequence.
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=>
            (r_state == wlaf_pkg::S_PREP || r_state == wlaf_pkg::S_LDIV))
        else $error("accepted sample did not start processing");

    // The leak update only follows a division by the window.
    a_leak_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wlaf_pkg::S_LEAK) |-> ($past(r_state) == wlaf_pkg::S_LDIV))
        else $error("leak update without a finished window division");

    // A result is only loaded when the output register can take it.
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("output register overwritten while full");
`endif

endmodule

`default_nettype wire
